[rtl/core/wmv_pkg.sv]
// Shared types and constants for the window mean and variance core.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package wmv_pkg;

    // Image geometry and sample width.
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int PIXEL_BITS = 8;
    localparam int COORD_W    = 8;
    localparam int DIM_W      = 9;
    localparam int RADIUS_W   = 7;
    localparam int TABLE_AW   = 2 * COORD_W;

    // Table and arithmetic widths.
    localparam int SUM_W      = 24;
    localparam int SQ_W       = 32;
    localparam int ROW_SUM_W  = 16;
    localparam int ROW_SQ_W   = 24;
    localparam int AREA_W     = 17;
    localparam int AREA_SQ_W  = 33;
    localparam int MEAN_NUM_W = SUM_W + 8;
    localparam int SA_W       = SQ_W + AREA_W;
    localparam int VAR_NUM_W  = SA_W + 8;
    localparam int QUOT_W     = 24;
    localparam int MEAN_W     = 16;
    localparam int VAR_W      = 24;

    // Configuration register indexes.
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_WINDOW_RADIUS = 2'd2;

    // Operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [1:0] ST_RANGE      = 2'd2;

    // Corner codes of the box sum.
    localparam logic [1:0] CORNER_LR = 2'd0;
    localparam logic [1:0] CORNER_UL = 2'd1;
    localparam logic [1:0] CORNER_LL = 2'd2;
    localparam logic [1:0] CORNER_UR = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_WR,
        S_READ,
        S_ACC,
        S_MUL,
        S_DIFF,
        S_DIV_START,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic       load_start;
        logic       load_write;
        logic       query_start;
        logic       rd_issue;
        logic [1:0] corner;
        logic       mul;
        logic       diff;
        logic       div_start;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic query_ok;
        logic div_busy;
        logic out_free;
    } stat_t;

endpackage

[rtl/core/wmv_div.sv]
// Restoring divider, one quotient bit per cycle.
// Standalone; the quotient must fit in QUOT_W bits.
`timescale 1ns / 1ps

module wmv_div #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 17,
    parameter int QUOT_W     = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [QUOT_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [QUOT_W-1:0]    quo_reg, quo_next;
    logic [DIVISOR_W:0]   rem_sh;
    logic [DIVISOR_W:0]   rem_diff;

    // One trial subtraction per cycle.
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[QUOT_W-1]};
        rem_diff = rem_sh - {1'b0, divisor};
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            cnt_next = CNT_W'(QUOT_W);
            rem_next = DIVISOR_W'(dividend[DIVIDEND_W-1:QUOT_W]);
            quo_next = dividend[QUOT_W-1:0];
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (rem_sh >= {1'b0, divisor})
            begin
                rem_next = rem_diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DIVISOR_W-1:0];
                quo_next = {quo_reg[QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

[rtl/core/wmv_ctrl.sv]
// Sequencer for loads and queries of the window mean and variance core.
// Depends on wmv_pkg; drives the datapath by command word, reads its status.
`timescale 1ns / 1ps

module wmv_ctrl
    import wmv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  op,
    input  stat_t stat,
    output logic  in_stall,
    output cmd_t  cmd
);

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = 2'd0;
                if (in_valid)
                begin
                    if (op == OP_LOAD)
                        state_next = S_LOAD_WR;
                    else if (stat.query_ok)
                        state_next = S_READ;
                    else
                        state_next = S_DONE;
                end
            end
            S_LOAD_WR:   state_next = S_IDLE;
            S_READ:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = S_ACC;
            end
            S_ACC:       state_next = S_MUL;
            S_MUL:       state_next = S_DIFF;
            S_DIFF:      state_next = S_DIV_START;
            S_DIV_START: state_next = S_DIV;
            S_DIV:
            begin
                if (!stat.div_busy)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Commands.
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall        = 1'b0;
                cmd.load_start  = in_valid && (op == OP_LOAD);
                cmd.query_start = in_valid && (op == OP_QUERY);
            end
            S_LOAD_WR:   cmd.load_write = 1'b1;
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                cmd.corner   = cnt_reg;
            end
            S_ACC:       cmd.rd_issue = 1'b0;
            S_MUL:       cmd.mul = 1'b1;
            S_DIFF:      cmd.diff = 1'b1;
            S_DIV_START: cmd.div_start = 1'b1;
            S_DIV:       cmd.mul = 1'b0;
            S_DONE:      cmd.out_load = stat.out_free;
            default:     cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[rtl/core/wmv_dp.sv]
// Datapath: configuration, summed-area tables, box sums, products, dividers
// and the output word register. Depends on wmv_pkg and wmv_div.
`timescale 1ns / 1ps

module wmv_dp
    import wmv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [DIM_W-1:0]      cfg_data,
    input  logic [PIXEL_BITS-1:0] pixel_value,
    input  logic [COORD_W-1:0]    query_x,
    input  logic [COORD_W-1:0]    query_y,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [MEAN_W-1:0]     window_mean,
    output logic [VAR_W-1:0]      window_variance,
    output logic [1:0]            status
);

    // Configuration and load state.
    logic [DIM_W-1:0]     width_reg, height_reg;
    logic [RADIUS_W-1:0]  radius_reg;
    logic [COORD_W-1:0]   lx_reg, ly_reg;
    logic                 complete_reg;
    logic [ROW_SUM_W-1:0] row_s_reg;
    logic [ROW_SQ_W-1:0]  row_q_reg;

    // Tables.
    logic [SUM_W-1:0]     sum_mem [0:(1 << TABLE_AW)-1];
    logic [SQ_W-1:0]      sq_mem  [0:(1 << TABLE_AW)-1];
    logic [SUM_W-1:0]     rd_s_reg;
    logic [SQ_W-1:0]      rd_q_reg;
    logic [TABLE_AW-1:0]  rd_addr;

    // Query registers.
    logic [COORD_W-1:0]   x0_reg, x1_reg, y0_reg, y1_reg;
    logic [1:0]           qstat_reg;
    logic                 rd_pend_reg, corner_zero_reg, corner_neg_reg;
    logic [SUM_W+1:0]     acc_s_reg;
    logic [SQ_W+1:0]      acc_q_reg;
    logic [AREA_W-1:0]    area_reg;
    logic [SA_W-1:0]      sa_reg;
    logic [2*SUM_W-1:0]   s2_reg;
    logic [AREA_SQ_W-1:0] aa_reg;
    logic [MEAN_NUM_W-1:0] mean_num_reg;
    logic [VAR_NUM_W-1:0] var_num_reg;

    // Output word.
    logic                 out_valid_reg;
    logic [MEAN_W-1:0]    mean_out_reg;
    logic [VAR_W-1:0]     var_out_reg;
    logic [1:0]           status_out_reg;

    logic [DIM_W-1:0]     w_eff, h_eff;
    logic                 range_bad;
    logic [1:0]           qstat;
    logic [COORD_W-1:0]   x0_c, x1_c, y0_c, y1_c;
    logic [DIM_W-1:0]     xs, ys;
    logic [COORD_W-1:0]   cx, cy;
    logic                 cz, cneg;
    logic                 last_col;
    logic [2*PIXEL_BITS-1:0] pix_sq;
    logic [SUM_W+1:0]     term_s;
    logic [SQ_W+1:0]      term_q;
    logic [SUM_W-1:0]     box_s;
    logic [SQ_W-1:0]      box_q;
    logic [DIM_W-1:0]     dx, dy;
    logic [SUM_W-1:0]     above_s;
    logic [SQ_W-1:0]      above_q;
    logic                 busy_m, busy_v;
    logic [QUOT_W-1:0]    quo_m, quo_v;

    // Effective dimensions and the query checks.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
        range_bad = (DIM_W'(query_x) >= w_eff) || (DIM_W'(query_y) >= h_eff);
        if (!complete_reg)
            qstat = ST_INCOMPLETE;
        else if (range_bad)
            qstat = ST_RANGE;
        else
            qstat = ST_OK;
    end

    // Window corners clipped per axis.
    always_comb
    begin
        x0_c = (query_x >= COORD_W'(radius_reg)) ? query_x - COORD_W'(radius_reg) : '0;
        y0_c = (query_y >= COORD_W'(radius_reg)) ? query_y - COORD_W'(radius_reg) : '0;
        xs   = DIM_W'(query_x) + DIM_W'(radius_reg);
        ys   = DIM_W'(query_y) + DIM_W'(radius_reg);
        x1_c = (xs > w_eff - 1'b1) ? COORD_W'(w_eff - 1'b1) : xs[COORD_W-1:0];
        y1_c = (ys > h_eff - 1'b1) ? COORD_W'(h_eff - 1'b1) : ys[COORD_W-1:0];
    end

    // Corner address for the box sum; a corner left of or above the image reads zero.
    always_comb
    begin
        case (cmd.corner)
            CORNER_LR:
            begin
                cx = x1_reg;  cy = y1_reg;  cz = 1'b0;  cneg = 1'b0;
            end
            CORNER_UL:
            begin
                cx = x0_reg - 1'b1;  cy = y0_reg - 1'b1;
                cz = (x0_reg == '0) || (y0_reg == '0);  cneg = 1'b0;
            end
            CORNER_LL:
            begin
                cx = x0_reg - 1'b1;  cy = y1_reg;  cz = (x0_reg == '0);  cneg = 1'b1;
            end
            CORNER_UR:
            begin
                cx = x1_reg;  cy = y0_reg - 1'b1;  cz = (y0_reg == '0);  cneg = 1'b1;
            end
            default:
            begin
                cx = x1_reg;  cy = y1_reg;  cz = 1'b0;  cneg = 1'b0;
            end
        endcase
        rd_addr = cmd.load_start ? {ly_reg - 1'b1, lx_reg} : {cy, cx};
    end

    // Arithmetic helpers.
    always_comb
    begin
        last_col = (DIM_W'(lx_reg) == w_eff - 1'b1);
        pix_sq   = pixel_value * pixel_value;
        term_s   = corner_zero_reg ? '0 : (SUM_W+2)'(rd_s_reg);
        term_q   = corner_zero_reg ? '0 : (SQ_W+2)'(rd_q_reg);
        box_s    = acc_s_reg[SUM_W+1] ? '0 : acc_s_reg[SUM_W-1:0];
        box_q    = acc_q_reg[SQ_W+1]  ? '0 : acc_q_reg[SQ_W-1:0];
        dx       = DIM_W'(x1_reg) - DIM_W'(x0_reg) + 1'b1;
        dy       = DIM_W'(y1_reg) - DIM_W'(y0_reg) + 1'b1;
        above_s  = (ly_reg != '0) ? rd_s_reg : '0;
        above_q  = (ly_reg != '0) ? rd_q_reg : '0;
    end

    // Table memories: one read and one write port each.
    always_ff @(posedge clk)
    begin
        rd_s_reg <= sum_mem[rd_addr];
        rd_q_reg <= sq_mem[rd_addr];
        if (cmd.load_write)
        begin
            sum_mem[{ly_reg, lx_reg}] <= above_s + SUM_W'(row_s_reg);
            sq_mem[{ly_reg, lx_reg}]  <= above_q + SQ_W'(row_q_reg);
        end
    end

    // Configuration, load position and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= DIM_W'(256);
            height_reg    <= DIM_W'(256);
            radius_reg    <= RADIUS_W'(1);
            lx_reg        <= '0;
            ly_reg        <= '0;
            complete_reg  <= 1'b0;
            row_s_reg     <= '0;
            row_q_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.rd_issue;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:
                    begin
                        width_reg    <= cfg_data;
                        lx_reg       <= '0;
                        ly_reg       <= '0;
                        complete_reg <= 1'b0;
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        height_reg   <= cfg_data;
                        lx_reg       <= '0;
                        ly_reg       <= '0;
                        complete_reg <= 1'b0;
                    end
                    REG_WINDOW_RADIUS: radius_reg <= cfg_data[RADIUS_W-1:0];
                    default:           radius_reg <= radius_reg;
                endcase
            end
            if (cmd.load_start)
            begin
                if (lx_reg == '0)
                begin
                    row_s_reg <= ROW_SUM_W'(pixel_value);
                    row_q_reg <= ROW_SQ_W'(pix_sq);
                end
                else
                begin
                    row_s_reg <= row_s_reg + ROW_SUM_W'(pixel_value);
                    row_q_reg <= row_q_reg + ROW_SQ_W'(pix_sq);
                end
                if ((lx_reg == '0) && (ly_reg == '0))
                    complete_reg <= 1'b0;
            end
            if (cmd.load_write)
            begin
                if (last_col)
                begin
                    lx_reg <= '0;
                    if (DIM_W'(ly_reg) == h_eff - 1'b1)
                    begin
                        ly_reg       <= '0;
                        complete_reg <= 1'b1;
                    end
                    else
                    begin
                        ly_reg <= ly_reg + 1'b1;
                    end
                end
                else
                begin
                    lx_reg <= lx_reg + 1'b1;
                end
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Query payload pipeline.
    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            x0_reg    <= x0_c;
            x1_reg    <= x1_c;
            y0_reg    <= y0_c;
            y1_reg    <= y1_c;
            qstat_reg <= qstat;
            acc_s_reg <= '0;
            acc_q_reg <= '0;
        end
        else if (rd_pend_reg)
        begin
            acc_s_reg <= corner_neg_reg ? acc_s_reg - term_s : acc_s_reg + term_s;
            acc_q_reg <= corner_neg_reg ? acc_q_reg - term_q : acc_q_reg + term_q;
        end
        if (cmd.rd_issue)
        begin
            corner_zero_reg <= cz;
            corner_neg_reg  <= cneg;
            area_reg        <= AREA_W'(dx) * AREA_W'(dy);
        end
        if (cmd.mul)
        begin
            sa_reg       <= SA_W'(box_q) * SA_W'(area_reg);
            s2_reg       <= box_s * box_s;
            aa_reg       <= AREA_SQ_W'(area_reg) * AREA_SQ_W'(area_reg);
            mean_num_reg <= {box_s, 8'd0};
        end
        if (cmd.diff)
            var_num_reg <= (sa_reg > SA_W'(s2_reg)) ? {sa_reg - SA_W'(s2_reg), 8'd0} : '0;
        if (cmd.out_load)
        begin
            status_out_reg <= qstat_reg;
            mean_out_reg   <= (qstat_reg == ST_OK) ? quo_m[MEAN_W-1:0] : '0;
            var_out_reg    <= (qstat_reg == ST_OK) ? quo_v[VAR_W-1:0] : '0;
        end
    end

    // Mean and variance dividers run side by side.
    wmv_div #(
        .DIVIDEND_W (MEAN_NUM_W),
        .DIVISOR_W  (AREA_W),
        .QUOT_W     (QUOT_W)
    ) u_div_mean (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mean_num_reg),
        .divisor  (area_reg),
        .busy     (busy_m),
        .quotient (quo_m)
    );

    wmv_div #(
        .DIVIDEND_W (VAR_NUM_W),
        .DIVISOR_W  (AREA_SQ_W),
        .QUOT_W     (QUOT_W)
    ) u_div_var (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (var_num_reg),
        .divisor  (aa_reg),
        .busy     (busy_v),
        .quotient (quo_v)
    );

    assign stat.query_ok   = (qstat == ST_OK);
    assign stat.div_busy   = busy_m || busy_v;
    assign stat.out_free   = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign window_mean     = mean_out_reg;
    assign window_variance = var_out_reg;
    assign status          = status_out_reg;

endmodule

[rtl/core/window_mean_variance_integral_core.sv]
// Window mean and variance from summed-area tables, top level.
// A load word reads the row above from the table, then writes; a rejected query goes to the output.
// A query word takes four corner reads per table, four arithmetic steps
// and the two restoring dividers, which set the rate. Its result word is then
// loaded for output; no new word is taken before that, and a stalled output holds the sequencer.
// Reset is asynchronous, active low; the tables are not cleared.
`timescale 1ns / 1ps

module window_mean_variance_integral_core
    import wmv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [DIM_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [PIXEL_BITS-1:0] pixel_value,
    input  logic [COORD_W-1:0]    query_x,
    input  logic [COORD_W-1:0]    query_y,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [MEAN_W-1:0]     window_mean,
    output logic [VAR_W-1:0]      window_variance,
    output logic [1:0]            status
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer.
    wmv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // Datapath and tables.
    wmv_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pixel_value     (pixel_value),
        .query_x         (query_x),
        .query_y         (query_y),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .window_mean     (window_mean),
        .window_variance (window_variance),
        .status          (status)
    );

endmodule
